// ===== rtl/core/gss_pkg.sv =====
package gss_pkg;

    localparam int DATA_W = 32;
    localparam int AW     = 15;
    localparam int DEPTH  = 1 << AW;
    localparam int CFG_W  = 5;
    localparam int CIDX_W = 3;
    // Neighbor-product sums stay below 2^50, so 52 signed bits hold them with margin.
    localparam int NUM_W  = 52;
    localparam int UN_W   = NUM_W - 1;
    localparam int SUM_W  = 64;
    localparam int FRAC_W = 16;
    localparam int RES_SHIFT = 20;

    localparam logic [CFG_W-1:0] CELLS_RST = 5'd30;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_SOLVE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_e;

    typedef enum logic [1:0] {
        COMP_SCALAR = 2'd0,
        COMP_X      = 2'd1,
        COMP_Y      = 2'd2,
        COMP_Z      = 2'd3
    } comp_e;

    typedef enum logic [CIDX_W-1:0] {
        CFG_CELLS_X  = 3'd0,
        CFG_CELLS_Y  = 3'd1,
        CFG_CELLS_Z  = 3'd2,
        CFG_BLK_ILO  = 3'd3,
        CFG_BLK_IHI  = 3'd4,
        CFG_BLK_JLO  = 3'd5,
        CFG_BLK_JHI  = 3'd6,
        CFG_BLK_KHI  = 3'd7
    } cfg_idx_e;

    typedef enum logic [2:0] {
        NB_EAST   = 3'd0,
        NB_WEST   = 3'd1,
        NB_NORTH  = 3'd2,
        NB_SOUTH  = 3'd3,
        NB_FRONT  = 3'd4,
        NB_BACK   = 3'd5,
        NB_CENTER = 3'd6,
        NB_NONE   = 3'd7
    } nb_e;

    typedef struct packed {
        logic signed [DATA_W-1:0] center;
        logic signed [DATA_W-1:0] east;
        logic signed [DATA_W-1:0] west;
        logic signed [DATA_W-1:0] north;
        logic signed [DATA_W-1:0] south;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] back;
        logic signed [DATA_W-1:0] source;
    } coef_t;

    typedef struct packed {
        logic cell_load;
        logic rd_issue;
        nb_e  rd_sel;
        logic unk_read;
        logic load_write;
        logic num_load;
        logic div_start;
        logic unk_write;
        logic sum_clear;
        logic res_acc;
        logic out_load;
        logic out_sel_read;
    } gss_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic ap_zero;
        logic div_done;
        logic more;
    } gss_sts_t;

endpackage

// ===== rtl/core/gss_div.sv =====
module gss_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gss_pkg::UN_W-1:0]   un,
    input  logic [gss_pkg::DATA_W-1:0] ud,
    input  logic                       neg,
    output logic                       done,
    output logic [gss_pkg::DATA_W-1:0] result
);
    import gss_pkg::*;

    localparam int Q_W = DATA_W - 1;
    localparam int SAT_SH = Q_W - FRAC_W;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [Q_W-1:0]   sh_reg, sh_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [DATA_W-1:0] ud_reg, ud_next;
    logic             neg_reg, neg_next;
    logic [DATA_W-1:0] result_reg, result_next;

    logic [DATA_W:0]  trial;
    logic             qbit;
    logic [DATA_W-1:0] r_step;
    logic [Q_W-1:0]   q_fin;
    logic             ovf;

    // The quotient only fits 31 bits when un < ud * 2^15; otherwise it saturates.
    assign ovf   = un >= (UN_W'(ud) << SAT_SH);
    assign trial = {r_reg, sh_reg[Q_W-1]};
    assign qbit  = trial >= {1'b0, ud_reg};
    assign r_step = qbit ? DATA_W'(trial - {1'b0, ud_reg}) : trial[DATA_W-1:0];
    assign q_fin = {q_reg[Q_W-2:0], qbit};

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        r_next      = r_reg;
        sh_next     = sh_reg;
        q_next      = q_reg;
        ud_next     = ud_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        if (start)
        begin
            ud_next  = ud;
            neg_next = neg;
            q_next   = '0;
            if (ovf)
            begin
                result_next = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
                done_next   = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = 5'(Q_W);
                r_next    = DATA_W'(un >> SAT_SH);
                sh_next   = {un[SAT_SH-1:0], {FRAC_W{1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            r_next   = r_step;
            q_next   = q_fin;
            sh_next  = sh_reg << 1;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next   = 1'b0;
                done_next   = 1'b1;
                result_next = neg_reg ? DATA_W'(0) - {1'b0, q_fin} : {1'b0, q_fin};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        sh_reg     <= sh_next;
        q_reg      <= q_next;
        ud_reg     <= ud_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/gss_datapath.sv =====
module gss_datapath #(
    parameter int IW   = 5,
    parameter int PJ_W = 6,
    parameter int PK_W = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gss_pkg::gss_cmd_t                 cmd,
    output gss_pkg::gss_sts_t                 sts,
    input  logic [IW-1:0]                     cell_i,
    input  logic [IW-1:0]                     cell_j,
    input  logic [IW-1:0]                     cell_k,
    input  logic [PJ_W-1:0]                   pitch_j,
    input  logic [PK_W-1:0]                   pitch_k,
    input  logic [gss_pkg::AW-1:0]            cell_address,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_center,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_east,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_west,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_north,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_south,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_front,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_back,
    input  logic signed [gss_pkg::DATA_W-1:0] source_term,
    input  logic signed [gss_pkg::DATA_W-1:0] initial_value,
    output logic signed [gss_pkg::DATA_W-1:0] value_out
);
    import gss_pkg::*;

    localparam int CA_W = PK_W + IW + 2;

    coef_t                    coef_mem [DEPTH];
    logic signed [DATA_W-1:0] unk_mem  [DEPTH];

    coef_t                    coef_rdata_reg;
    logic signed [DATA_W-1:0] unk_rdata_reg;
    logic [AW-1:0]            c_reg;
    logic                     rd_valid_reg;
    nb_e                      rd_tag_reg;
    logic signed [63:0]       prod_reg;
    logic                     prod_valid_reg;
    nb_e                      prod_tag_reg;
    logic signed [NUM_W-1:0]  acc_reg;
    logic signed [NUM_W-1:0]  d_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [SUM_W-1:0]         s1_reg, s1_next;
    logic [SUM_W-1:0]         s2_reg, s2_next;
    logic signed [DATA_W-1:0] value_out_reg;

    logic [CA_W-1:0]          c_full;
    logic [AW-1:0]            nb_addr;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic signed [DATA_W-1:0] coef_sel;
    logic signed [63:0]       prod_c;
    logic signed [NUM_W-1:0]  prod_q;
    logic [UN_W-1:0]          num_mag;
    logic [DATA_W-1:0]        ap_mag;
    logic                     div_done;
    logic [DATA_W-1:0]        div_result;
    logic signed [NUM_W:0]    r_sig;
    logic [NUM_W:0]           r_mag;
    logic [NUM_W-1:0]         d_mag;
    logic [SUM_W:0]           s1_sum, s2_sum;
    coef_t                    coef_wdata;

    assign c_full = CA_W'(cell_i) + CA_W'(pitch_j) * CA_W'(cell_j)
                  + CA_W'(pitch_k) * CA_W'(cell_k);

    always_comb
    begin
        case (cmd.rd_sel)
            NB_EAST:  nb_addr = c_reg + AW'(1);
            NB_WEST:  nb_addr = c_reg - AW'(1);
            NB_NORTH: nb_addr = c_reg + AW'(pitch_j);
            NB_SOUTH: nb_addr = c_reg - AW'(pitch_j);
            NB_FRONT: nb_addr = c_reg + AW'(pitch_k);
            NB_BACK:  nb_addr = c_reg - AW'(pitch_k);
            default:  nb_addr = c_reg;
        endcase
    end

    assign rd_addr = cmd.unk_read ? cell_address : nb_addr;
    assign wr_addr = cmd.load_write ? cell_address : c_reg;
    assign wr_data = cmd.load_write ? initial_value : $signed(div_result);

    assign coef_wdata = '{center: coef_center, east: coef_east, west: coef_west,
                          north: coef_north, south: coef_south, front: coef_front,
                          back: coef_back, source: source_term};

    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
        begin
            coef_mem[cell_address] <= coef_wdata;
        end
        if (cmd.rd_issue)
        begin
            coef_rdata_reg <= coef_mem[c_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_write || cmd.unk_write)
        begin
            unk_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue || cmd.unk_read)
        begin
            unk_rdata_reg <= unk_mem[rd_addr];
        end
    end

    always_comb
    begin
        case (rd_tag_reg)
            NB_EAST:   coef_sel = coef_rdata_reg.east;
            NB_WEST:   coef_sel = coef_rdata_reg.west;
            NB_NORTH:  coef_sel = coef_rdata_reg.north;
            NB_SOUTH:  coef_sel = coef_rdata_reg.south;
            NB_FRONT:  coef_sel = coef_rdata_reg.front;
            NB_BACK:   coef_sel = coef_rdata_reg.back;
            NB_CENTER: coef_sel = coef_rdata_reg.center;
            default:   coef_sel = '0;
        endcase
    end

    assign prod_c = coef_sel * unk_rdata_reg;
    // Arithmetic shift drops the fraction with rounding toward minus infinity.
    assign prod_q = NUM_W'(prod_reg >>> FRAC_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.rd_issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_tag_reg   <= cmd.rd_sel;
        prod_reg     <= prod_c;
        prod_tag_reg <= rd_tag_reg;
        if (cmd.cell_load)
        begin
            c_reg   <= AW'(c_full);
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            if (prod_tag_reg == NB_CENTER)
            begin
                d_reg <= prod_q;
            end
            else
            begin
                acc_reg <= acc_reg + prod_q;
            end
        end
        if (cmd.num_load)
        begin
            num_reg <= acc_reg + NUM_W'(coef_rdata_reg.source);
        end
    end

    assign num_mag = num_reg[NUM_W-1] ? UN_W'(-num_reg) : UN_W'(num_reg);
    assign ap_mag  = coef_rdata_reg.center[DATA_W-1] ? DATA_W'(0) - coef_rdata_reg.center
                                                     : coef_rdata_reg.center;

    gss_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .un     (num_mag),
        .ud     (ap_mag),
        .neg    (num_reg[NUM_W-1] ^ coef_rdata_reg.center[DATA_W-1]),
        .done   (div_done),
        .result (div_result)
    );

    // Residual terms: r = center product - neighbor products - source.
    assign r_sig  = (NUM_W+1)'(d_reg) - (NUM_W+1)'(num_reg);
    assign r_mag  = r_sig[NUM_W] ? (~r_sig + 1'b1) : r_sig;
    assign d_mag  = d_reg[NUM_W-1] ? (~d_reg + 1'b1) : d_reg;
    assign s1_sum = {1'b0, s1_reg} + (SUM_W+1)'(r_mag);
    assign s2_sum = {1'b0, s2_reg} + (SUM_W+1)'(d_mag);

    always_comb
    begin
        s1_next = s1_reg;
        s2_next = s2_reg;
        if (cmd.sum_clear)
        begin
            s1_next = '0;
            s2_next = SUM_W'(1);
        end
        else if (cmd.res_acc)
        begin
            s1_next = s1_sum[SUM_W] ? {SUM_W{1'b1}} : s1_sum[SUM_W-1:0];
            s2_next = s2_sum[SUM_W] ? {SUM_W{1'b1}} : s2_sum[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        if (cmd.out_load)
        begin
            value_out_reg <= cmd.out_sel_read ? unk_rdata_reg : '0;
        end
    end

    assign sts.pipe_busy = rd_valid_reg | prod_valid_reg;
    assign sts.ap_zero   = coef_rdata_reg.center == '0;
    assign sts.div_done  = div_done;
    assign sts.more      = s1_reg > (s2_reg >> RES_SHIFT);
    assign value_out     = value_out_reg;

endmodule

// ===== rtl/core/gss_ctrl.sv =====
module gss_ctrl #(
    parameter int MAX_DIM  = 30,
    parameter int MAX_ITER = 5,
    parameter int IW       = 5,
    parameter int PJ_W     = 6,
    parameter int PK_W     = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    func,
    input  logic [1:0]                    component,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gss_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [gss_pkg::CFG_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    iterations_done,
    output logic                          converged,
    output gss_pkg::gss_cmd_t             cmd,
    input  gss_pkg::gss_sts_t             sts,
    output logic [IW-1:0]                 cell_i,
    output logic [IW-1:0]                 cell_j,
    output logic [IW-1:0]                 cell_k,
    output logic [PJ_W-1:0]               pitch_j,
    output logic [PK_W-1:0]               pitch_k
);
    import gss_pkg::*;

    localparam int IT_W = $clog2(MAX_ITER + 1);
    localparam int SW   = 8;
    localparam logic [2:0] PASS_RES = 3'd4;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_DELIVER = 13'b0000000000010,
        ST_SETUP   = 13'b0000000000100,
        ST_ITER    = 13'b0000000001000,
        ST_CELL    = 13'b0000000010000,
        ST_FETCH   = 13'b0000000100000,
        ST_DRAIN   = 13'b0000001000000,
        ST_NUM     = 13'b0000010000000,
        ST_DIVGO   = 13'b0000100000000,
        ST_DIV     = 13'b0001000000000,
        ST_RES     = 13'b0010000000000,
        ST_STEP    = 13'b0100000000000,
        ST_CHECK   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] cx_reg, cy_reg, cz_reg, bil_reg, bih_reg, bjl_reg, bjh_reg, bkh_reg;
    logic [IW-1:0]    lim_i_reg, lim_i_next, lim_j_reg, lim_j_next, lim_k_reg, lim_k_next;
    logic signed [SW-1:0] blo_i_reg, blo_i_next, blo_j_reg, blo_j_next;
    logic [PJ_W-1:0]  pj_reg, pj_next;
    logic [PK_W-1:0]  pk_reg, pk_next;
    logic [IT_W-1:0]  iter_reg, iter_next;
    logic [2:0]       pass_reg, pass_next;
    logic [IW-1:0]    a_reg, a_next, b_reg, b_next, k_reg, k_next;
    logic [2:0]       n_reg, n_next;
    logic [2:0]       last_iters_reg, last_iters_next;
    logic             last_conv_reg, last_conv_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_iters_reg;
    logic             out_conv_reg;
    logic             rd_item_reg, rd_item_next;
    comp_e            comp_reg, comp_next;

    logic [IW-1:0]    nx_c, ny_c, nz_c;
    logic [PJ_W-1:0]  pj_c;
    logic [IW-1:0]    na, nb, pa, pb, ci, cj;
    logic             rev, empty, skip, slot_free, relax;
    logic             k_last, b_last, a_last;
    logic signed [SW-1:0] si, sj, sk;
    logic [IT_W+2:0]  iter_ext;
    nb_e              last_tag;

    assign nx_c = (int'(cx_reg) > MAX_DIM) ? IW'(MAX_DIM) : IW'(cx_reg);
    assign ny_c = (int'(cy_reg) > MAX_DIM) ? IW'(MAX_DIM) : IW'(cy_reg);
    assign nz_c = (int'(cz_reg) > MAX_DIM) ? IW'(MAX_DIM) : IW'(cz_reg);
    assign pj_c = PJ_W'(nx_c) + PJ_W'(2);

    assign relax = pass_reg != PASS_RES;
    assign rev   = pass_reg[1];
    assign na    = pass_reg[0] ? lim_j_reg : lim_i_reg;
    assign nb    = pass_reg[0] ? lim_i_reg : lim_j_reg;
    assign pa    = rev ? na + IW'(1) - a_reg : a_reg;
    assign pb    = rev ? nb + IW'(1) - b_reg : b_reg;
    assign ci    = pass_reg[0] ? pb : pa;
    assign cj    = pass_reg[0] ? pa : pb;
    assign empty = (na == '0) || (nb == '0) || (lim_k_reg == '0);
    assign si    = $signed(SW'(ci));
    assign sj    = $signed(SW'(cj));
    assign sk    = $signed(SW'(k_reg));
    assign skip  = (si > blo_i_reg) && (si <= $signed(SW'(bih_reg)))
                && (sj > blo_j_reg) && (sj <= $signed(SW'(bjh_reg)))
                && (sk <= $signed(SW'(bkh_reg)));
    assign k_last = k_reg == lim_k_reg;
    assign b_last = b_reg == nb;
    assign a_last = a_reg == na;
    assign slot_free = !out_valid_reg || out_ready;
    assign last_tag  = relax ? NB_BACK : NB_CENTER;
    assign iter_ext  = (IT_W+3)'(iter_reg);

    always_comb
    begin
        state_next      = state_reg;
        lim_i_next      = lim_i_reg;
        lim_j_next      = lim_j_reg;
        lim_k_next      = lim_k_reg;
        blo_i_next      = blo_i_reg;
        blo_j_next      = blo_j_reg;
        pj_next         = pj_reg;
        pk_next         = pk_reg;
        iter_next       = iter_reg;
        pass_next       = pass_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        last_iters_next = last_iters_reg;
        last_conv_next  = last_conv_reg;
        rd_item_next    = rd_item_reg;
        comp_next       = comp_reg;
        cmd             = '0;
        cmd.rd_sel      = nb_e'(n_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rd_item_next = 1'b0;
                    case (func_e'(func))
                        FUNC_SOLVE:
                        begin
                            // The component is only valid on the accepting edge.
                            comp_next  = comp_e'(component);
                            state_next = ST_SETUP;
                        end
                        FUNC_READ:
                        begin
                            cmd.unk_read = 1'b1;
                            rd_item_next = 1'b1;
                            state_next   = ST_DELIVER;
                        end
                        default:
                        begin
                            cmd.load_write = func_e'(func) == FUNC_LOAD;
                            if (slot_free)
                            begin
                                cmd.out_load = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_DELIVER;
                            end
                        end
                    endcase
                end
            end
            ST_DELIVER:
            begin
                if (slot_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_sel_read = rd_item_reg;
                    state_next       = ST_IDLE;
                end
            end
            ST_SETUP:
            begin
                lim_i_next = nx_c;
                lim_j_next = ny_c;
                lim_k_next = nz_c;
                blo_i_next = $signed(SW'(bil_reg));
                blo_j_next = $signed(SW'(bjl_reg));
                pj_next    = pj_c;
                pk_next    = PK_W'(pj_c) * PK_W'(PJ_W'(ny_c) + PJ_W'(2));
                iter_next  = '0;
                case (comp_reg)
                    COMP_X:
                    begin
                        lim_i_next = (nx_c == '0) ? '0 : nx_c - IW'(1);
                        blo_i_next = $signed(SW'(bil_reg)) - SW'(1);
                    end
                    COMP_Y:
                    begin
                        lim_j_next = (ny_c == '0) ? '0 : ny_c - IW'(1);
                        blo_j_next = $signed(SW'(bjl_reg)) - SW'(1);
                    end
                    COMP_Z:
                    begin
                        lim_k_next = (nz_c == '0) ? '0 : nz_c - IW'(1);
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                iter_next     = iter_reg + IT_W'(1);
                pass_next     = '0;
                a_next        = IW'(1);
                b_next        = IW'(1);
                k_next        = IW'(1);
                cmd.sum_clear = 1'b1;
                state_next    = ST_CELL;
            end
            ST_CELL:
            begin
                if (empty || skip)
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    cmd.cell_load = 1'b1;
                    n_next        = '0;
                    state_next    = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.rd_issue = 1'b1;
                if (nb_e'(n_reg) == last_tag)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    n_next = n_reg + 3'd1;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:
            begin
                cmd.num_load = 1'b1;
                if (!relax)
                begin
                    state_next = ST_RES;
                end
                else if (sts.ap_zero)
                begin
                    state_next = ST_STEP;
                end
                else
                begin
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.unk_write = 1'b1;
                    state_next    = ST_STEP;
                end
            end
            ST_RES:
            begin
                cmd.res_acc = 1'b1;
                state_next  = ST_STEP;
            end
            ST_STEP:
            begin
                state_next = ST_CELL;
                if (empty || (k_last && b_last && a_last))
                begin
                    a_next = IW'(1);
                    b_next = IW'(1);
                    k_next = IW'(1);
                    if (pass_reg == PASS_RES)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        pass_next = pass_reg + 3'd1;
                    end
                end
                else if (!k_last)
                begin
                    k_next = k_reg + IW'(1);
                end
                else
                begin
                    k_next = IW'(1);
                    if (!b_last)
                    begin
                        b_next = b_reg + IW'(1);
                    end
                    else
                    begin
                        b_next = IW'(1);
                        a_next = a_reg + IW'(1);
                    end
                end
            end
            ST_CHECK:
            begin
                if (sts.more && (iter_reg < IT_W'(MAX_ITER)))
                begin
                    state_next = ST_ITER;
                end
                else
                begin
                    last_iters_next = iter_ext[2:0];
                    last_conv_next  = !sts.more;
                    rd_item_next    = 1'b0;
                    state_next      = ST_DELIVER;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cx_reg         <= CELLS_RST;
            cy_reg         <= CELLS_RST;
            cz_reg         <= CELLS_RST;
            bil_reg        <= '0;
            bih_reg        <= '0;
            bjl_reg        <= '0;
            bjh_reg        <= '0;
            bkh_reg        <= '0;
            last_iters_reg <= '0;
            last_conv_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_item_reg    <= 1'b0;
            iter_reg       <= '0;
            pass_reg       <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            last_iters_reg <= last_iters_next;
            last_conv_reg  <= last_conv_next;
            out_valid_reg  <= out_valid_next;
            rd_item_reg    <= rd_item_next;
            iter_reg       <= iter_next;
            pass_reg       <= pass_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            k_reg          <= k_next;
            n_reg          <= n_next;
            if (cfg_valid)
            begin
                case (cfg_idx_e'(cfg_index))
                    CFG_CELLS_X: cx_reg  <= cfg_data;
                    CFG_CELLS_Y: cy_reg  <= cfg_data;
                    CFG_CELLS_Z: cz_reg  <= cfg_data;
                    CFG_BLK_ILO: bil_reg <= cfg_data;
                    CFG_BLK_IHI: bih_reg <= cfg_data;
                    CFG_BLK_JLO: bjl_reg <= cfg_data;
                    CFG_BLK_JHI: bjh_reg <= cfg_data;
                    CFG_BLK_KHI: bkh_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lim_i_reg <= lim_i_next;
        lim_j_reg <= lim_j_next;
        lim_k_reg <= lim_k_next;
        blo_i_reg <= blo_i_next;
        blo_j_reg <= blo_j_next;
        pj_reg    <= pj_next;
        pk_reg    <= pk_next;
        comp_reg  <= comp_next;
        if (cmd.out_load)
        begin
            out_iters_reg <= last_iters_next;
            out_conv_reg  <= last_conv_next;
        end
    end

    assign in_ready        = state_reg == ST_IDLE;
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign iterations_done = out_iters_reg;
    assign converged       = out_conv_reg;
    assign cell_i          = ci;
    assign cell_j          = cj;
    assign cell_k          = k_reg;
    assign pitch_j         = pj_reg;
    assign pitch_k         = pk_reg;

endmodule

// ===== rtl/core/gauss_seidel_stencil_solver_unit.sv =====
// Load beat: its result is registered at the accepting edge when the output register is
// free. Read beat: the word read at acceptance goes to the output register once it is free.
// Solve beat: a relaxed cell takes six reads on the single unknown-memory port, a pipeline
// drain and a 31-step bit-serial divider; a residual cell does not divide, and neither does
// a cell with a zero center. A solve runs up to MAX_ITER iterations; one beat is in work
// at a time. Reset (rst_n, asynchronous, active low) restores the configuration; memories
// keep data.
module gauss_seidel_stencil_solver_unit #(
    parameter int MAX_DIM  = 30,
    parameter int MAX_ITER = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        func,
    input  logic [gss_pkg::AW-1:0]            cell_address,
    input  logic [1:0]                        component,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_center,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_east,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_west,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_north,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_south,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_front,
    input  logic signed [gss_pkg::DATA_W-1:0] coef_back,
    input  logic signed [gss_pkg::DATA_W-1:0] source_term,
    input  logic signed [gss_pkg::DATA_W-1:0] initial_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [gss_pkg::DATA_W-1:0] value_out,
    output logic [2:0]                        iterations_done,
    output logic                              converged,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gss_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [gss_pkg::CFG_W-1:0]         cfg_data
);
    import gss_pkg::*;

    // Cell indices run 1..MAX_DIM; the plane and row pitches include the halo.
    localparam int IW   = $clog2(MAX_DIM + 2);
    localparam int PJ_W = IW + 1;
    localparam int PK_W = 2 * PJ_W;

    gss_cmd_t        cmd;
    gss_sts_t        sts;
    logic [IW-1:0]   cell_i;
    logic [IW-1:0]   cell_j;
    logic [IW-1:0]   cell_k;
    logic [PJ_W-1:0] pitch_j;
    logic [PK_W-1:0] pitch_k;

    // The controller walks the four sweep orders and the residual pass cell by cell and
    // sequences each cell through fetch, accumulate, divide and write-back.
    gss_ctrl #(
        .MAX_DIM  (MAX_DIM),
        .MAX_ITER (MAX_ITER),
        .IW       (IW),
        .PJ_W     (PJ_W),
        .PK_W     (PK_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .component       (component),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .iterations_done (iterations_done),
        .converged       (converged),
        .cmd             (cmd),
        .sts             (sts),
        .cell_i          (cell_i),
        .cell_j          (cell_j),
        .cell_k          (cell_k),
        .pitch_j         (pitch_j),
        .pitch_k         (pitch_k)
    );

    // The datapath owns the coefficient and unknown memories, the multiply-accumulate
    // pipeline, the divider and the residual sums.
    gss_datapath #(
        .IW   (IW),
        .PJ_W (PJ_W),
        .PK_W (PK_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cell_i        (cell_i),
        .cell_j        (cell_j),
        .cell_k        (cell_k),
        .pitch_j       (pitch_j),
        .pitch_k       (pitch_k),
        .cell_address  (cell_address),
        .coef_center   (coef_center),
        .coef_east     (coef_east),
        .coef_west     (coef_west),
        .coef_north    (coef_north),
        .coef_south    (coef_south),
        .coef_front    (coef_front),
        .coef_back     (coef_back),
        .source_term   (source_term),
        .initial_value (initial_value),
        .value_out     (value_out)
    );

endmodule
